// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the offset fit block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition cons must hold in the same cycle as ante.
`define RBSOF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Condition cons must hold in the cycle after ante.
`define RBSOF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/rbsof_pkg.sv =====
// Types and constants shared by the offset fit block.
`timescale 1ns / 1ps
package rbsof_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_OWN_NODE_ID = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_TIME_SHIFT  = 4'd1;

    localparam logic [2:0] OWN_NODE_ID_RESET = 3'd1;
    localparam logic [4:0] TIME_SHIFT_RESET  = 5'd10;

    localparam logic [23:0] X_MAX = 24'hFFFFFF;

    // One peer report waiting for the arithmetic side.
    typedef struct packed {
        logic [2:0]  sender;
        logic [63:0] remote;
        logic [63:0] latched;
    } rbsof_job_t;

endpackage

// ===== hw/rtl/rbs_sliding_window_offset_fit.sv =====
// Top level of the reference-broadcast clock offset estimator.
`timescale 1ns / 1ps
// Usage
// The input stream carries beacons and peer reports. s_tuser is the mode:
// 0 for a beacon, whose local time is latched, 1 for a peer report. A report
// from a peer other than this node stores one sample in that sender's window
// of the last WINDOW samples and yields one item on the result stream with
// the mean offset, the Q16.16 least-squares slope, the intercept, the fitted
// offset at the newest sample and the sample count; m_tuser flags a valid fit.
// Beacons, own reports and senders outside the table yield nothing.
// A report with a valid fit needs eleven products on the shared 64 by 64
// multiplier and three bit-serial quotients; with an invalid fit only ten
// products and the mean are needed. A two-item queue sits between the
// input side and the arithmetic side, so up to two reports are taken while a
// report is in work, and a result waiting in the output register does not
// stop the next report from being worked on. When the receiver stalls, the
// result holds; the next report then waits until the register is free.
// Reset (synchronous, active low) clears the latched time, fill counts, write
// slots and sums and sets own_node_id to 1 and time_shift to 10. The config
// channel is always ready and should only be written while the block is idle.
module rbs_sliding_window_offset_fit
    import rbsof_pkg::*;
#(
    parameter int NUM_PEERS = 8,
    parameter int WINDOW    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [135:0]          s_tdata,   // sender[2:0], local_stamp[66:3],
                                             // remote_stamp[130:67]
    input  logic                  s_tuser,   // mode
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [135:0]          m_tdata,   // peer[2:0], avg_offset[34:3], slope[66:35],
                                             // intercept[98:67], fitted_offset[130:99],
                                             // sample_count[135:131]
    output logic                  m_tuser,   // fit_valid
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [2:0] own_node_id_reg;
    logic [4:0] time_shift_reg;
    rbsof_job_t job;
    logic       job_valid;
    logic       job_pop;

    assign cfg_ready = 1'b1;

    // Writes to indexes beyond the register list are taken and dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_node_id_reg <= OWN_NODE_ID_RESET;
            time_shift_reg  <= TIME_SHIFT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_REG_OWN_NODE_ID: own_node_id_reg <= cfg_data[2:0];
                CFG_REG_TIME_SHIFT:  time_shift_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    rbsof_front #(
        .NUM_PEERS (NUM_PEERS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .own_node_id_i (own_node_id_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .job_o         (job),
        .job_valid_o   (job_valid),
        .job_pop_i     (job_pop)
    );

    rbsof_back #(
        .NUM_PEERS (NUM_PEERS),
        .WINDOW    (WINDOW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .time_shift_i (time_shift_reg),
        .job_i        (job),
        .job_valid_i  (job_valid),
        .job_pop_o    (job_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// ===== hw/rtl/rbsof_front.sv =====
// Input side: takes items, latches beacon times and queues peer reports.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbsof_front
    import rbsof_pkg::*;
#(
    parameter int NUM_PEERS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [2:0]   own_node_id_i,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic         s_tuser,
    output rbsof_job_t   job_o,
    output logic         job_valid_o,
    input  logic         job_pop_i
);

    logic [63:0] latched_reg;
    rbsof_job_t  ent_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        accept;
    logic        push;
    logic [2:0]  sender;

    assign sender   = s_tdata[2:0];
    assign s_tready = (cnt_reg != 2'd2);
    assign accept   = s_tvalid & s_tready;
    // Reports from this node or from a sender outside the table are dropped here.
    assign push     = accept & s_tuser & (sender != own_node_id_i)
                      & (32'(sender) < NUM_PEERS);

    assign job_o       = ent_reg[rp_reg];
    assign job_valid_o = (cnt_reg != 2'd0);

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !job_pop_i) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && job_pop_i) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_reg <= '0;
            wp_reg      <= 1'b0;
            rp_reg      <= 1'b0;
            cnt_reg     <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (accept && !s_tuser) begin
                latched_reg <= s_tdata[66:3];
            end
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (job_pop_i) begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= '{sender: sender, remote: s_tdata[130:67],
                                 latched: latched_reg};
        end
    end

    `RBSOF_ASSERT_IMPL(a_pop_not_empty, aclk, aresetn, job_pop_i, cnt_reg != 2'd0)

endmodule

// ===== hw/rtl/rbsof_mul.sv =====
// Signed 64 by 64 multiplier built from four 32 by 32 partial products.
`timescale 1ns / 1ps
module rbsof_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start_i,
    input  logic [63:0]  a_i,
    input  logic [63:0]  b_i,
    output logic         busy_o,
    output logic         done_o,
    output logic [127:0] p_o
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_FIN  = 2'd2;

    logic [1:0]   state_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    logic [127:0] p_reg;
    logic         done_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shifted;

    assign busy_o = (state_reg != M_IDLE);
    assign done_o = done_reg;
    assign p_o    = p_reg;

    // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
    assign a_half = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign b_half = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];

    always_comb begin
        unique case (cnt_reg)
            3'd1:    pp_shifted = 128'(pp_reg);
            3'd2,
            3'd3:    pp_shifted = 128'(pp_reg) << 32;
            3'd4:    pp_shifted = 128'(pp_reg) << 64;
            default: pp_shifted = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (start_i) begin
                        state_reg <= M_RUN;
                        cnt_reg   <= 3'd0;
                    end
                end
                M_RUN: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4) begin
                        state_reg <= M_FIN;
                    end
                end
                M_FIN: begin
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == M_IDLE && start_i) begin
            ua_reg  <= a_i[63] ? (64'd0 - a_i) : a_i;
            ub_reg  <= b_i[63] ? (64'd0 - b_i) : b_i;
            neg_reg <= a_i[63] ^ b_i[63];
            acc_reg <= '0;
        end
        if (state_reg == M_RUN) begin
            pp_reg  <= 64'(a_half) * 64'(b_half);
            acc_reg <= acc_reg + pp_shifted;
        end
        if (state_reg == M_FIN) begin
            p_reg <= neg_reg ? (128'd0 - acc_reg) : acc_reg;
        end
    end

endmodule

// ===== hw/rtl/rbsof_div.sv =====
// Bit-serial signed divider with a 32-bit saturated quotient.
`timescale 1ns / 1ps
module rbsof_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start_i,
    input  logic [127:0] num_i,
    input  logic [63:0]  den_i,
    output logic         done_o,
    output logic [31:0]  q_o
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;
    localparam logic [1:0] D_FIN  = 2'd3;

    logic [1:0]   state_reg;
    logic [4:0]   cnt_reg;
    logic [127:0] m_reg;
    logic [63:0]  den_reg;
    logic [63:0]  r_reg;
    logic [30:0]  q_reg;
    logic         neg_reg;
    logic         sat_reg;
    logic [31:0]  q_out_reg;
    logic         done_reg;
    logic [64:0]  r_trial;
    logic         fits;

    assign done_o  = done_reg;
    assign q_o     = q_out_reg;
    assign r_trial = {r_reg, m_reg[30]};
    assign fits    = (r_trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start_i) begin
                        state_reg <= D_CHK;
                    end
                end
                D_CHK: begin
                    cnt_reg   <= 5'd31;
                    state_reg <= (m_reg[127:31] >= {33'd0, den_reg}) ? D_FIN : D_RUN;
                end
                D_RUN: begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            D_IDLE: begin
                if (start_i) begin
                    m_reg   <= num_i[127] ? (128'd0 - num_i) : num_i;
                    neg_reg <= num_i[127];
                    den_reg <= den_i;
                end
            end
            D_CHK: begin
                // A quotient of 2^31 or more saturates whatever the sign.
                sat_reg <= (m_reg[127:31] >= {33'd0, den_reg});
                r_reg   <= m_reg[94:31];
                q_reg   <= '0;
            end
            D_RUN: begin
                m_reg <= m_reg << 1;
                q_reg <= {q_reg[29:0], fits};
                if (fits) begin
                    r_reg <= 64'(r_trial - {1'b0, den_reg});
                end else begin
                    r_reg <= r_trial[63:0];
                end
            end
            D_FIN: begin
                if (sat_reg) begin
                    q_out_reg <= neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    q_out_reg <= neg_reg ? (32'd0 - {1'b0, q_reg}) : {1'b0, q_reg};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/rbsof_back.sv =====
// Arithmetic side: window update, running sums, regression and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbsof_back
    import rbsof_pkg::*;
#(
    parameter int NUM_PEERS = 8,
    parameter int WINDOW    = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [4:0]   time_shift_i,
    input  rbsof_job_t   job_i,
    input  logic         job_valid_i,
    output logic         job_pop_o,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,
    output logic         m_tuser
);

    localparam int PW    = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int DEPTH = NUM_PEERS * WINDOW;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_LOAD  = 4'd1;
    localparam logic [3:0] B_UPD   = 4'd2;
    localparam logic [3:0] B_MGO   = 4'd3;
    localparam logic [3:0] B_MWAIT = 4'd4;
    localparam logic [3:0] B_DGO   = 4'd5;
    localparam logic [3:0] B_DWAIT = 4'd6;
    localparam logic [3:0] B_FIT   = 4'd7;
    localparam logic [3:0] B_OUT   = 4'd8;

    localparam logic [3:0] ST_RXY   = 4'd0;
    localparam logic [3:0] ST_RXX   = 4'd1;
    localparam logic [3:0] ST_AXY   = 4'd2;
    localparam logic [3:0] ST_AXX   = 4'd3;
    localparam logic [3:0] ST_NSXX  = 4'd4;
    localparam logic [3:0] ST_SXSX  = 4'd5;
    localparam logic [3:0] ST_NSXY  = 4'd6;
    localparam logic [3:0] ST_SXSY  = 4'd7;
    localparam logic [3:0] ST_SXXSY = 4'd8;
    localparam logic [3:0] ST_SXSXY = 4'd9;
    localparam logic [3:0] ST_MEAN  = 4'd10;
    localparam logic [3:0] ST_SLOPE = 4'd11;
    localparam logic [3:0] ST_ICPT  = 4'd12;
    localparam logic [3:0] ST_FITM  = 4'd13;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        if (v[63] && !(&v[62:31])) begin
            return 32'h8000_0000;
        end else if (!v[63] && (|v[62:31])) begin
            return 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    logic [3:0]    state_reg;
    logic [3:0]    step_reg;

    logic [63:0]   base_mem   [NUM_PEERS];
    logic [CW-1:0] fill_reg   [NUM_PEERS];
    logic [SW-1:0] slot_reg   [NUM_PEERS];
    logic [39:0]   sum_x_reg  [NUM_PEERS];
    logic [39:0]   sum_y_reg  [NUM_PEERS];
    logic [63:0]   sum_xy_reg [NUM_PEERS];
    logic [63:0]   sum_xx_reg [NUM_PEERS];

    // Window store, one row per sender, entry holds {y, x}.
    logic [55:0]   win_mem [DEPTH];
    logic [55:0]   win_rd_reg;

    logic [PW-1:0] s_reg;
    logic [2:0]    sender_reg;
    logic [AW-1:0] addr_reg;
    logic [63:0]   remote_reg;
    logic [63:0]   lat_reg;
    logic [23:0]   x_reg;
    logic [31:0]   y_reg;
    logic          full_reg;
    logic [127:0]  t_reg;
    logic [63:0]   denom_reg;
    logic [127:0]  num_reg;
    logic [127:0]  inum_reg;
    logic [31:0]   mean_reg;
    logic [31:0]   slope_reg;
    logic [31:0]   icpt_reg;
    logic [31:0]   fit_reg;
    logic          valid_reg;

    logic          m_tvalid_reg;
    logic [135:0]  m_tdata_reg;
    logic          m_tuser_reg;

    logic [PW-1:0] head_s;
    logic [AW-1:0] head_addr;
    logic [63:0]   base_eff;
    logic [63:0]   diff;
    logic [63:0]   diff_sh;
    logic [63:0]   dy;
    logic [23:0]   x_new;
    logic [23:0]   ox;
    logic [31:0]   oy;
    logic [CW-1:0] n_cur;
    logic [63:0]   mul_a;
    logic [63:0]   mul_b;
    logic          mul_start;
    logic          mul_busy;
    logic          mul_done;
    logic [127:0]  mul_p;
    logic [127:0]  div_num;
    logic [63:0]   div_den;
    logic          div_start;
    logic          div_done;
    logic [31:0]   div_q;
    logic signed [63:0] prod_s;
    logic signed [63:0] prod_q16;
    logic [63:0]   fit_sum;

    assign head_s    = PW'(job_i.sender);
    assign head_addr = AW'(32'(head_s) * WINDOW + 32'(slot_reg[head_s]));
    assign job_pop_o = (state_reg == B_IDLE) && job_valid_i;

    assign base_eff = (fill_reg[s_reg] == '0) ? lat_reg : base_mem[s_reg];
    assign diff     = (lat_reg >= base_eff) ? (lat_reg - base_eff) : 64'd0;
    assign diff_sh  = diff >> time_shift_i;
    assign x_new    = (|diff_sh[63:24]) ? X_MAX : diff_sh[23:0];
    assign dy       = remote_reg - lat_reg;

    // The oldest sample only leaves the sums once the window is full.
    assign ox    = full_reg ? win_rd_reg[23:0] : 24'd0;
    assign oy    = full_reg ? win_rd_reg[55:24] : 32'd0;
    assign n_cur = fill_reg[s_reg];

    always_comb begin
        unique case (step_reg)
            ST_RXY:   begin mul_a = 64'(ox); mul_b = {{32{oy[31]}}, oy}; end
            ST_RXX:   begin mul_a = 64'(ox); mul_b = 64'(ox); end
            ST_AXY:   begin mul_a = 64'(x_reg); mul_b = {{32{y_reg[31]}}, y_reg}; end
            ST_AXX:   begin mul_a = 64'(x_reg); mul_b = 64'(x_reg); end
            ST_NSXX:  begin mul_a = 64'(n_cur); mul_b = sum_xx_reg[s_reg]; end
            ST_SXSX:  begin
                mul_a = {{24{sum_x_reg[s_reg][39]}}, sum_x_reg[s_reg]};
                mul_b = {{24{sum_x_reg[s_reg][39]}}, sum_x_reg[s_reg]};
            end
            ST_NSXY:  begin mul_a = 64'(n_cur); mul_b = sum_xy_reg[s_reg]; end
            ST_SXSY:  begin
                mul_a = {{24{sum_x_reg[s_reg][39]}}, sum_x_reg[s_reg]};
                mul_b = {{24{sum_y_reg[s_reg][39]}}, sum_y_reg[s_reg]};
            end
            ST_SXXSY: begin
                mul_a = sum_xx_reg[s_reg];
                mul_b = {{24{sum_y_reg[s_reg][39]}}, sum_y_reg[s_reg]};
            end
            ST_SXSXY: begin
                mul_a = {{24{sum_x_reg[s_reg][39]}}, sum_x_reg[s_reg]};
                mul_b = sum_xy_reg[s_reg];
            end
            ST_FITM:  begin mul_a = {{32{slope_reg[31]}}, slope_reg}; mul_b = 64'(x_reg); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        unique case (step_reg)
            ST_MEAN:  begin
                div_num = {{88{sum_y_reg[s_reg][39]}}, sum_y_reg[s_reg]};
                div_den = 64'(n_cur);
            end
            ST_SLOPE: begin div_num = {num_reg[111:0], 16'd0}; div_den = denom_reg; end
            ST_ICPT:  begin div_num = inum_reg; div_den = denom_reg; end
            default:  begin div_num = '0; div_den = 64'd1; end
        endcase
    end

    assign mul_start = (state_reg == B_MGO);
    assign div_start = (state_reg == B_DGO);

    // Q16.16 product back to whole units, rounded toward zero.
    assign prod_s   = signed'(mul_p[63:0]);
    assign prod_q16 = (prod_s[63] ? (prod_s + 64'sd65535) : prod_s) >>> 16;
    assign fit_sum  = {{32{icpt_reg[31]}}, icpt_reg} + 64'(prod_q16);

    rbsof_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (mul_start),
        .a_i     (mul_a),
        .b_i     (mul_b),
        .busy_o  (mul_busy),
        .done_o  (mul_done),
        .p_o     (mul_p)
    );

    rbsof_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .num_i   (div_num),
        .den_i   (div_den),
        .done_o  (div_done),
        .q_o     (div_q)
    );

    always_ff @(posedge aclk) begin
        if (job_pop_o) begin
            win_rd_reg <= win_mem[head_addr];
        end
        if (state_reg == B_UPD) begin
            win_mem[addr_reg] <= {y_reg, x_reg};
        end
    end

    // Control state and the per-sender records that reset clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            step_reg     <= ST_RXY;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_PEERS; i++) begin
                fill_reg[i]   <= '0;
                slot_reg[i]   <= '0;
                sum_x_reg[i]  <= '0;
                sum_y_reg[i]  <= '0;
                sum_xy_reg[i] <= '0;
                sum_xx_reg[i] <= '0;
            end
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (job_valid_i) begin
                        state_reg <= B_LOAD;
                    end
                end
                B_LOAD: begin
                    state_reg <= B_UPD;
                end
                B_UPD: begin
                    if (!full_reg) begin
                        fill_reg[s_reg] <= fill_reg[s_reg] + CW'(1);
                    end
                    slot_reg[s_reg] <= (slot_reg[s_reg] == SW'(WINDOW - 1)) ? '0
                                       : slot_reg[s_reg] + SW'(1);
                    sum_x_reg[s_reg] <= sum_x_reg[s_reg] - 40'(ox) + 40'(x_reg);
                    sum_y_reg[s_reg] <= sum_y_reg[s_reg] - {{8{oy[31]}}, oy}
                                        + {{8{y_reg[31]}}, y_reg};
                    step_reg  <= ST_RXY;
                    state_reg <= B_MGO;
                end
                B_MGO: begin
                    state_reg <= B_MWAIT;
                end
                B_MWAIT: begin
                    if (mul_done) begin
                        state_reg <= B_MGO;
                        step_reg  <= step_reg + 4'd1;
                        unique case (step_reg)
                            ST_RXY: sum_xy_reg[s_reg] <= sum_xy_reg[s_reg] - mul_p[63:0];
                            ST_RXX: sum_xx_reg[s_reg] <= sum_xx_reg[s_reg] - mul_p[63:0];
                            ST_AXY: sum_xy_reg[s_reg] <= sum_xy_reg[s_reg] + mul_p[63:0];
                            ST_AXX: sum_xx_reg[s_reg] <= sum_xx_reg[s_reg] + mul_p[63:0];
                            ST_SXSXY: begin
                                step_reg  <= ST_MEAN;
                                state_reg <= B_DGO;
                            end
                            ST_FITM: state_reg <= B_FIT;
                            default: ;
                        endcase
                    end
                end
                B_DGO: begin
                    state_reg <= B_DWAIT;
                end
                B_DWAIT: begin
                    if (div_done) begin
                        state_reg <= B_DGO;
                        step_reg  <= step_reg + 4'd1;
                        if (step_reg == ST_MEAN && denom_reg == 64'd0) begin
                            state_reg <= B_OUT;
                        end else if (step_reg == ST_ICPT) begin
                            state_reg <= B_MGO;
                        end
                    end
                end
                B_FIT: begin
                    state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Item payload and intermediate results.
    always_ff @(posedge aclk) begin
        if (job_pop_o) begin
            s_reg      <= head_s;
            sender_reg <= job_i.sender;
            addr_reg   <= head_addr;
            remote_reg <= job_i.remote;
            lat_reg    <= job_i.latched;
        end
        if (state_reg == B_LOAD) begin
            if (fill_reg[s_reg] == '0) begin
                base_mem[s_reg] <= lat_reg;
            end
            x_reg    <= x_new;
            y_reg    <= sat32(dy);
            full_reg <= (32'(fill_reg[s_reg]) >= WINDOW);
        end
        if (state_reg == B_MWAIT && mul_done) begin
            unique case (step_reg)
                ST_NSXX, ST_NSXY, ST_SXXSY: t_reg <= mul_p;
                ST_SXSX:  denom_reg <= 64'(t_reg - mul_p);
                ST_SXSY:  num_reg   <= t_reg - mul_p;
                ST_SXSXY: inum_reg  <= t_reg - mul_p;
                default: ;
            endcase
        end
        if (state_reg == B_DWAIT && div_done) begin
            unique case (step_reg)
                ST_MEAN: begin
                    mean_reg  <= div_q;
                    valid_reg <= (denom_reg != 64'd0);
                    slope_reg <= '0;
                    icpt_reg  <= '0;
                    fit_reg   <= '0;
                end
                ST_SLOPE: slope_reg <= div_q;
                ST_ICPT:  icpt_reg  <= div_q;
                default: ;
            endcase
        end
        if (state_reg == B_FIT) begin
            fit_reg <= sat32(fit_sum);
        end
        if (state_reg == B_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {5'(n_cur), fit_reg, icpt_reg, slope_reg, mean_reg, sender_reg};
            m_tuser_reg <= valid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `RBSOF_ASSERT_IMPL(a_mul_start_idle, aclk, aresetn, mul_start, !mul_busy)
    `RBSOF_ASSERT_NEXT(a_pop_to_load, aclk, aresetn, job_pop_o, state_reg == B_LOAD)
    `RBSOF_ASSERT_IMPL(a_invalid_fit_zero, aclk, aresetn, m_tvalid && !m_tuser,
        m_tdata[130:35] == 96'd0)

endmodule
